// File: rtl/core/kdlpr_pkg.sv
// Shared types and constants for the key debounce and long-press reset core.
package kdlpr_pkg;

	// Input command codes
	localparam logic CMD_KEY  = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// Key identifiers
	localparam logic KEY_PWR     = 1'b0;
	localparam logic KEY_VOLDOWN = 1'b1;

	// Result kinds
	localparam logic KIND_REPORT = 1'b0;
	localparam logic KIND_RESET  = 1'b1;

	// Configuration register indexes
	localparam int CFG_INDEX_WIDTH = 3;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEBOUNCE_CODE = 3'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_WIDE_DEBOUNCE = 3'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_FIRST_HOLD    = 3'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_SECOND_HOLD   = 3'd3;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_BOOT_GUARD    = 3'd4;

	localparam int CFG_WIDTH = 26;

	// Register reset values
	localparam logic [CFG_WIDTH-1:0] FIRST_HOLD_RESET  = 26'd3000000;
	localparam logic [CFG_WIDTH-1:0] SECOND_HOLD_RESET = 26'd4000000;
	localparam logic [CFG_WIDTH-1:0] BOOT_GUARD_RESET  = 26'd60000000;

	// Debounce span in microseconds; shifted right by the code-derived amount
	localparam int DEBOUNCE_WIDTH = 21;
	localparam logic [DEBOUNCE_WIDTH-1:0] DEBOUNCE_SPAN_US = 21'd2000000;

	// Control into one key slice
	typedef struct packed {
		logic tick;     // one-microsecond tick applied this cycle
		logic evt;      // debounced key event for this key applied this cycle
		logic pressed;  // level carried by the event
		logic guard;    // boot guard passed (including this event's check)
	} key_ctl_t;

	// Status out of one key slice
	typedef struct packed {
		logic db_ok;        // debounce window has elapsed
		logic prev_pressed; // last reported level
		logic expire2;      // second hold stage completes on this tick
		logic stage2;       // second hold stage already done
	} key_sts_t;

	// One result word
	typedef struct packed {
		logic kind;
		logic key_id;
		logic key_state;
		logic last;
	} result_t;

endpackage

// File: rtl/core/key_debounce_long_press_reset_core.sv
// Top level: input stage, boot guard, two key slices and a two-word result queue.
// Input path: an accepted word is held in the input stage until the queue has room, then
//   its results are loaded into the result queue and the first is presented on m_tvalid.
// Throughput: one word per cycle while each word yields at most one result and the sink
//   keeps up; a two-result word holds the input while the queue drains.
// Reset: arst_n clears counters, flags, input stage and queue at once; no clearing pass.
module key_debounce_long_press_reset_core #(
	parameter int TIME_WIDTH = 26
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	// input stream
	input  logic                                    s_tvalid,
	output logic                                    s_tready,
	input  logic [7:0]                              s_tdata,  // [0] pressed
	input  logic [1:0]                              s_tuser,  // [0] command, [1] key_select
	// result stream
	output logic                                    m_tvalid,
	input  logic                                    m_tready,
	output logic [7:0]                              m_tdata,  // [0] key_state
	output logic [1:0]                              m_tuser,  // [0] kind, [1] key_id
	output logic                                    m_tlast,
	// configuration writes
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [kdlpr_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
	input  logic [kdlpr_pkg::CFG_WIDTH-1:0]         cfg_data
);

	// Configuration registers
	logic [3:0]                      db_code_q;
	logic                            db_wide_q;
	logic [kdlpr_pkg::CFG_WIDTH-1:0] first_q;
	logic [kdlpr_pkg::CFG_WIDTH-1:0] second_q;
	logic [kdlpr_pkg::CFG_WIDTH-1:0] guard_cfg_q;

	// Time values seen at the counter width
	logic [TIME_WIDTH-1:0] first_t;
	logic [TIME_WIDTH-1:0] second_t;
	logic [TIME_WIDTH-1:0] guard_t;
	logic [TIME_WIDTH-1:0] debounce_t;
	logic [3:0]            db_shift;

	// Input stage
	logic valid_s1;
	logic cmd_s1;
	logic sel_s1;
	logic pressed_s1;

	// Boot guard
	logic [TIME_WIDTH-1:0] uptime_q;
	logic                  guard_q;
	logic                  guard_now;

	// Key slices
	kdlpr_pkg::key_ctl_t ctl [2];
	kdlpr_pkg::key_sts_t sts [2];

	// Result queue (entry 0 is the head)
	kdlpr_pkg::result_t ent_q [2];
	logic [1:0]         cnt_q;

	// Processing
	logic               adv;
	logic               pop;
	logic               is_tick;
	logic               ev_ok;
	logic               fire0;
	logic               fire1;
	kdlpr_pkg::result_t res0;
	kdlpr_pkg::result_t res1;
	logic [1:0]         res_n;

	// Configuration is always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			db_code_q   <= '0;
			db_wide_q   <= 1'b0;
			first_q     <= kdlpr_pkg::FIRST_HOLD_RESET;
			second_q    <= kdlpr_pkg::SECOND_HOLD_RESET;
			guard_cfg_q <= kdlpr_pkg::BOOT_GUARD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				kdlpr_pkg::REG_DEBOUNCE_CODE: db_code_q   <= cfg_data[3:0];
				kdlpr_pkg::REG_WIDE_DEBOUNCE: db_wide_q   <= cfg_data[0];
				kdlpr_pkg::REG_FIRST_HOLD:    first_q     <= cfg_data;
				kdlpr_pkg::REG_SECOND_HOLD:   second_q    <= cfg_data;
				kdlpr_pkg::REG_BOOT_GUARD:    guard_cfg_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Truncate or zero-extend the programmed times to the counter width
	assign first_t  = TIME_WIDTH'(first_q);
	assign second_t = TIME_WIDTH'(second_q);
	assign guard_t  = TIME_WIDTH'(guard_cfg_q);

	// Debounce time: span shifted right by 15 minus the code in wide mode, else by 7 minus its low three bits
	assign db_shift   = db_wide_q ? (4'd15 - db_code_q) : (4'd7 - {1'b0, db_code_q[2:0]});
	assign debounce_t = TIME_WIDTH'(kdlpr_pkg::DEBOUNCE_SPAN_US >> db_shift);

	// Queue holds at most two words; a new item runs only when the queue will
	// be empty after this cycle's pop, so both of its results always fit
	assign pop      = m_tvalid && m_tready;
	assign adv      = valid_s1 && ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop));
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1     <= s_tuser[0];
			sel_s1     <= s_tuser[1];
			pressed_s1 <= s_tdata[0];
		end
	end

	assign is_tick   = (cmd_s1 == kdlpr_pkg::CMD_TICK);
	assign ev_ok     = sts[sel_s1].db_ok;
	assign guard_now = guard_q || (uptime_q >= guard_t);

	// Uptime stops at the guard; guard check is made on a debounced event
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			uptime_q <= '0;
			guard_q  <= 1'b0;
		end else if (adv) begin
			if (is_tick) begin
				if (uptime_q < guard_t) begin
					uptime_q <= uptime_q + TIME_WIDTH'(1);
				end
			end else if (ev_ok) begin
				guard_q <= guard_now;
			end
		end
	end

	for (genvar k = 0; k < 2; k++) begin : g_key
		assign ctl[k].tick    = adv && is_tick;
		assign ctl[k].evt     = adv && !is_tick && (sel_s1 == 1'(k)) && sts[k].db_ok;
		assign ctl[k].pressed = pressed_s1;
		assign ctl[k].guard   = guard_now;

		kdlpr_key #(
			.TIME_WIDTH (TIME_WIDTH)
		) u_key (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl[k]),
			.first_t    (first_t),
			.second_t   (second_t),
			.debounce_t (debounce_t),
			.sts        (sts[k])
		);
	end

	// Force reset: power key is handled first, so the volume-down key sees the
	// power key's second stage as soon as it completes on the same tick
	assign fire0 = sts[0].expire2 && sts[1].stage2;
	assign fire1 = sts[1].expire2 && (sts[0].stage2 || sts[0].expire2);

	always_comb begin
		res0  = '0;
		res1  = '0;
		res_n = 2'd0;
		if (is_tick) begin
			if (fire0 && fire1) begin
				res0  = '{kdlpr_pkg::KIND_RESET, kdlpr_pkg::KEY_PWR, 1'b0, 1'b0};
				res1  = '{kdlpr_pkg::KIND_RESET, kdlpr_pkg::KEY_VOLDOWN, 1'b0, 1'b1};
				res_n = 2'd2;
			end else if (fire0) begin
				res0  = '{kdlpr_pkg::KIND_RESET, kdlpr_pkg::KEY_PWR, 1'b0, 1'b1};
				res_n = 2'd1;
			end else if (fire1) begin
				res0  = '{kdlpr_pkg::KIND_RESET, kdlpr_pkg::KEY_VOLDOWN, 1'b0, 1'b1};
				res_n = 2'd1;
			end
		end else if (ev_ok) begin
			// Release with no press reported first: insert the missing press
			if (!sts[sel_s1].prev_pressed && !pressed_s1) begin
				res0  = '{kdlpr_pkg::KIND_REPORT, sel_s1, 1'b1, 1'b0};
				res1  = '{kdlpr_pkg::KIND_REPORT, sel_s1, pressed_s1, 1'b1};
				res_n = 2'd2;
			end else begin
				res0  = '{kdlpr_pkg::KIND_REPORT, sel_s1, pressed_s1, 1'b1};
				res_n = 2'd1;
			end
		end
	end

	// Queue: load both entries when an item runs, else shift on pop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (adv) begin
			cnt_q <= res_n;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ent_q[0] <= res0;
			ent_q[1] <= res1;
		end else if (pop) begin
			ent_q[0] <= ent_q[1];
		end
	end

	assign m_tvalid = (cnt_q != 2'd0);
	assign m_tdata  = {7'd0, ent_q[0].key_state};
	assign m_tuser  = {ent_q[0].key_id, ent_q[0].kind};
	assign m_tlast  = ent_q[0].last;

	// Queue never overfills
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result queue count out of range");

	// A two-result item leaves both words queued
	a_two_results: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && res_n == 2'd2) |=> (cnt_q == 2'd2))
		else $error("second result word lost");

	// Boot guard is sticky
	a_guard_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		guard_q |=> guard_q)
		else $error("boot guard flag dropped");

	// Force reset words carry a released state
	a_reset_state: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0] == kdlpr_pkg::KIND_RESET) |-> (m_tdata[0] == 1'b0))
		else $error("force reset word with pressed state");

	// The head of a queued pair is never the word marked last
	a_last_mark: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && cnt_q == 2'd2) |-> !m_tlast)
		else $error("last marker on head of a pair");

endmodule

// File: rtl/core/kdlpr_key.sv
// Per-key slice: release counter, reported level, hold timer and stage flags.
module kdlpr_key #(
	parameter int TIME_WIDTH = 26
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  kdlpr_pkg::key_ctl_t    ctl,
	input  logic [TIME_WIDTH-1:0]  first_t,
	input  logic [TIME_WIDTH-1:0]  second_t,
	input  logic [TIME_WIDTH-1:0]  debounce_t,
	output kdlpr_pkg::key_sts_t    sts
);

	logic [TIME_WIDTH-1:0] since_q;
	logic [TIME_WIDTH-1:0] timer_q;
	logic                  pressed_q;
	logic                  armed_q;
	logic                  stage1_q;
	logic                  stage2_q;
	logic                  expire;

	// Timer runs out when armed and at one or zero left
	assign expire = ctl.tick && armed_q && (timer_q <= TIME_WIDTH'(1));

	assign sts.db_ok        = (since_q >= debounce_t);
	assign sts.prev_pressed = pressed_q;
	assign sts.expire2      = expire && stage1_q;
	assign sts.stage2       = stage2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			since_q   <= '0;
			timer_q   <= '0;
			pressed_q <= 1'b0;
			armed_q   <= 1'b0;
			stage1_q  <= 1'b0;
			stage2_q  <= 1'b0;
		end else if (ctl.tick) begin
			if (since_q != '1) begin
				since_q <= since_q + TIME_WIDTH'(1);
			end
			if (armed_q) begin
				if (!expire) begin
					timer_q <= timer_q - TIME_WIDTH'(1);
				end else if (!stage1_q) begin
					stage1_q <= 1'b1;
					timer_q  <= second_t;
				end else begin
					stage2_q <= 1'b1;
					armed_q  <= 1'b0;
					timer_q  <= '0;
				end
			end
		end else if (ctl.evt) begin
			if (ctl.guard) begin
				if (ctl.pressed) begin
					armed_q <= 1'b1;
					timer_q <= first_t;
				end else begin
					armed_q  <= 1'b0;
					timer_q  <= '0;
					stage1_q <= 1'b0;
					stage2_q <= 1'b0;
				end
			end
			if (!ctl.pressed) begin
				since_q <= '0;
			end
			pressed_q <= ctl.pressed;
		end
	end

endmodule
